// ===== hdl/bpfl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpfl_pkg
// Types and constants shared by the buffer pool free list block.
// ----------------------------------------------------------------------------
package bpfl_pkg;

	// Pool geometry.
	localparam int NUM_SLOTS = 32;
	localparam int IDX_W     = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int SLOT_W    = 5;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 2;

	// Register reset values.
	localparam logic [CFG_W-1:0] HEADROOM_RST = CFG_W'(2);
	localparam logic [CFG_W-1:0] RESUME_RST   = CFG_W'(16);

	typedef enum logic {
		CMD_RESERVE = 1'b0,
		CMD_FREE    = 1'b1
	} cmd_t;

	typedef enum logic {
		CLS_REQUEST    = 1'b0,
		CLS_INDICATION = 1'b1
	} item_class_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_REFUSED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADROOM = 2'd0,
		REG_RESUME   = 2'd1
	} reg_idx_t;

	typedef struct packed {
		cmd_t              cmd;
		item_class_t       item_class;
		logic [SLOT_W-1:0] slot_in;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_out;
		logic              allow_reception;
		logic [CNT_W-1:0]  free_count;
	} rsp_t;

endpackage
`default_nettype wire

// ===== hdl/buffer_pool_free_list_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// buffer_pool_free_list_top
// LIFO free list of buffer slot indices with headroom for indication reserves.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  -----------------------------------
//   command   start / busy              req  (cmd, item_class, slot_in)
//   result    done (one-cycle strobe)   rsp  (status, slot_out,
//                                             allow_reception, free_count)
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An item is handled in order: accepting it registers the item and issues the
// read of the stack top from the slot memory; then, once the registered read
// data is back, the count is updated, a returned slot is written and the
// result is registered. The result strobe is high in the cycle after that, and
// a new item can be accepted in that same cycle; no new item is taken while one
// is in flight, since the slot memory read is registered.
// Reset clears the count to a full pool and marks every memory entry as never
// written; such an entry reads as its own index, so no clearing pass is run.
// The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
module buffer_pool_free_list_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  bpfl_pkg::req_t                req,
	output logic                                done,
	output bpfl_pkg::rsp_t                      rsp,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [bpfl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [bpfl_pkg::CFG_W-1:0]          cfg_data
);

	// Configuration registers.
	logic [bpfl_pkg::CFG_W-1:0] headroom_q;
	logic [bpfl_pkg::CFG_W-1:0] resume_q;

	// Pool state: free count, slot memory and one written flag per entry.
	logic [bpfl_pkg::CNT_W-1:0]  total_q;
	logic [bpfl_pkg::SLOT_W-1:0] stack_mem [bpfl_pkg::NUM_SLOTS];
	logic [bpfl_pkg::NUM_SLOTS-1:0] written_q;

	// Stage 1: the item in flight and the stack top read for it.
	logic                        valid_s1;
	bpfl_pkg::req_t              req_s1;
	logic [bpfl_pkg::IDX_W-1:0]  addr_s1;
	logic [bpfl_pkg::SLOT_W-1:0] rd_data_s1;
	logic                        rd_written_s1;

	// Result register.
	logic           done_q;
	bpfl_pkg::rsp_t rsp_q;

	logic                        accept;
	logic [bpfl_pkg::IDX_W-1:0]  rd_addr;
	logic [bpfl_pkg::IDX_W-1:0]  wr_addr;
	logic                        pop_ok;
	logic                        push_ok;
	logic [bpfl_pkg::CNT_W-1:0]  total_next;
	logic [bpfl_pkg::SLOT_W-1:0] top_slot;
	logic                        pool_full;
	bpfl_pkg::rsp_t              rsp_next;

	assign accept    = start && !busy;
	assign busy      = valid_s1;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// The top of the stack sits one below the count.
	assign rd_addr   = bpfl_pkg::IDX_W'(total_q - bpfl_pkg::CNT_W'(1));
	assign wr_addr   = total_q[bpfl_pkg::IDX_W-1:0];
	assign pool_full = (total_q >= bpfl_pkg::CNT_W'(bpfl_pkg::NUM_SLOTS));

	// An entry that was never written still holds its reset content, its index.
	assign top_slot = rd_written_s1 ? rd_data_s1 : bpfl_pkg::SLOT_W'(addr_s1);

	always_comb begin
		pop_ok     = 1'b0;
		push_ok    = 1'b0;
		total_next = total_q;
		rsp_next   = '{status: bpfl_pkg::ST_DONE, slot_out: '0,
			allow_reception: 1'b0, free_count: total_q};
		case (req_s1.cmd)
			bpfl_pkg::CMD_RESERVE: begin
				// An indication reserve must leave the headroom behind it.
				if (total_q == '0) begin
					pop_ok = 1'b0;
				end else if (req_s1.item_class == bpfl_pkg::CLS_REQUEST) begin
					pop_ok = 1'b1;
				end else begin
					pop_ok = (total_q > headroom_q);
				end
				if (pop_ok) begin
					total_next        = total_q - bpfl_pkg::CNT_W'(1);
					rsp_next.slot_out = top_slot;
				end else begin
					rsp_next.status = bpfl_pkg::ST_REFUSED;
				end
			end
			default: begin
				if (pool_full) begin
					rsp_next.status = bpfl_pkg::ST_FULL;
				end else begin
					push_ok                  = 1'b1;
					total_next               = total_q + bpfl_pkg::CNT_W'(1);
					rsp_next.allow_reception = (total_next >= resume_q);
				end
			end
		endcase
		rsp_next.free_count = total_next;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			headroom_q <= bpfl_pkg::HEADROOM_RST;
			resume_q   <= bpfl_pkg::RESUME_RST;
			total_q    <= bpfl_pkg::CNT_W'(bpfl_pkg::NUM_SLOTS);
			written_q  <= '0;
			valid_s1   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					bpfl_pkg::REG_HEADROOM: headroom_q <= cfg_data;
					bpfl_pkg::REG_RESUME:   resume_q   <= cfg_data;
					default: ;
				endcase
			end
			valid_s1 <= accept;
			done_q   <= valid_s1;
			if (valid_s1) begin
				total_q <= total_next;
				if (push_ok) begin
					written_q[wr_addr] <= 1'b1;
				end
			end
		end
	end

	// Payload of the item in flight and of the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1        <= req;
			addr_s1       <= rd_addr;
			rd_written_s1 <= written_q[rd_addr];
		end
		if (valid_s1) begin
			rsp_q <= rsp_next;
		end
	end

	// Slot memory: one synchronous read port, one write port.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= stack_mem[rd_addr];
		end
		if (valid_s1 && push_ok) begin
			stack_mem[wr_addr] <= req_s1.slot_in;
		end
	end

	// Only one item is ever in flight.
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("second item entered while one was in flight");

	// A result strobe follows in the cycle after its item was in flight.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in flight");

	// The count never exceeds the pool.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= bpfl_pkg::CNT_W'(bpfl_pkg::NUM_SLOTS))
		else $error("free count beyond pool size");

	// A refused or rejected item reports no slot and the count unchanged.
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_next.status != bpfl_pkg::ST_DONE)
		|=> (rsp.slot_out == '0) && !rsp.allow_reception
			&& (total_q == $past(total_q)))
		else $error("refused item changed state or reported a slot");

	// Reception is only re-enabled by a completed free.
	a_allow_on_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.allow_reception) |-> (rsp.status == bpfl_pkg::ST_DONE))
		else $error("allow_reception raised on a failed item");

endmodule
`default_nettype wire
